/* rtl/wcae_pkg.sv */
package wcae_pkg;

  // size of the assignment store, one bit per variable
  localparam int unsigned MAX_VARIABLES = 65536;
  localparam int unsigned VAR_AW        = (MAX_VARIABLES > 1) ? $clog2(MAX_VARIABLES) : 1;

  // compare width that covers any index against any store size
  localparam int unsigned CMP_W    = 26;

  localparam int unsigned OPC_W    = 2;
  localparam int unsigned VAR_W    = 16;
  localparam int unsigned LIT_W    = 17;
  localparam int unsigned WEIGHT_W = 32;
  localparam int unsigned COST_W   = 48;

  // decoupling queue between front and back, power of two
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [OPC_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_HARD   = 2'd1,
    OP_SOFT   = 2'd2,
    OP_FINISH = 2'd3
  } op_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e                 op;
    logic                matched;
    logic                clause_end;
    logic [WEIGHT_W-1:0] weight;
  } work_t;

  // queue fill status seen by the front
  typedef struct packed {
    logic full;
    logic almost_full;
  } q_stat_t;

endpackage

/* rtl/weighted_cnf_assignment_evaluator.sv */
// a finish word passes the front stage register and the queue before the back registers its result for the ports
// throughput: one word per cycle while full stays low, literals and writes alike
// the figure is set by the single read and single write port of the assignment store
// an unread result stalls only a second finish; words behind it fill the queue, then full rises
// reset: asynchronous active low; clears clause state, sets the hard flag, zeroes the cost
// reset leaves the assignment store undefined until written, there is no clearing pass
module weighted_cnf_assignment_evaluator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input side, a queue seen from outside
  input  logic                          push,
  output logic                          full,
  input  logic [wcae_pkg::OPC_W-1:0]    opcode_i,
  input  logic [wcae_pkg::VAR_W-1:0]    variable_index_i,
  input  logic                          variable_value_i,
  input  logic signed [wcae_pkg::LIT_W-1:0] literal_i,
  input  logic                          clause_end_i,
  input  logic [wcae_pkg::WEIGHT_W-1:0] soft_weight_i,
  // result side
  output logic                          empty,
  input  logic                          pop,
  output logic                          hard_all_satisfied_o,
  output logic [wcae_pkg::COST_W-1:0]   soft_cost_o
);
  import wcae_pkg::*;

  // front to queue
  logic    q_push;
  work_t   q_work;
  q_stat_t q_stat;

  // queue to back
  logic    q_avail;
  logic    q_pop;
  work_t   q_head;

  // front: decodes the word, writes or reads the assignment store, and
  // tags each literal with its match bit in the cycle after it is accepted
  wcae_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push),
    .full_o           (full),
    .opcode_i         (opcode_i),
    .variable_index_i (variable_index_i),
    .variable_value_i (variable_value_i),
    .literal_i        (literal_i),
    .clause_end_i     (clause_end_i),
    .soft_weight_i    (soft_weight_i),
    .q_stat_i         (q_stat),
    .q_push_o         (q_push),
    .q_work_o         (q_work)
  );

  // short queue so a waiting result stops the front only once it fills
  wcae_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .work_i  (q_work),
    .pop_i   (q_pop),
    .avail_o (q_avail),
    .head_o  (q_head),
    .stat_o  (q_stat)
  );

  // back: folds matches into clauses, keeps the hard flag and the
  // saturating soft cost, and holds the reported result
  wcae_back u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .avail_i              (q_avail),
    .head_i               (q_head),
    .q_pop_o              (q_pop),
    .empty_o              (empty),
    .pop_i                (pop),
    .hard_all_satisfied_o (hard_all_satisfied_o),
    .soft_cost_o          (soft_cost_o)
  );

endmodule

/* rtl/wcae_ram.sv */
module wcae_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/wcae_front.sv */
module wcae_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic [wcae_pkg::OPC_W-1:0]    opcode_i,
  input  logic [wcae_pkg::VAR_W-1:0]    variable_index_i,
  input  logic                          variable_value_i,
  input  logic signed [wcae_pkg::LIT_W-1:0] literal_i,
  input  logic                          clause_end_i,
  input  logic [wcae_pkg::WEIGHT_W-1:0] soft_weight_i,
  input  wcae_pkg::q_stat_t             q_stat_i,
  output logic                          q_push_o,
  output wcae_pkg::work_t               q_work_o
);
  import wcae_pkg::*;

  op_e               op;
  logic              acc;
  logic              is_lit;
  logic [LIT_W-1:0]  lit_raw;
  logic              lit_neg;
  logic [LIT_W-1:0]  lit_mag;
  logic [CMP_W-1:0]  mag_ext;
  logic [CMP_W-1:0]  idx_ext;
  logic              lit_ok;
  logic              wr_ok;
  logic              ram_we;
  logic              ram_re;
  logic              ram_rdata;

  logic                s1_valid_q, s1_valid_d;
  op_e                 s1_op_q;
  logic                s1_lit_ok_q;
  logic                s1_neg_q;
  logic                s1_end_q;
  logic [WEIGHT_W-1:0] s1_weight_q;

  // front stalls only when the queue could not absorb the word in flight
  assign full_o = q_stat_i.full | (s1_valid_q & q_stat_i.almost_full);

  always_comb begin
    op      = op_e'(opcode_i);
    acc     = push_i & ~full_o;
    is_lit  = (op == OP_HARD) || (op == OP_SOFT);
    lit_raw = literal_i;
    lit_neg = lit_raw[LIT_W-1];
    lit_mag = lit_neg ? (~lit_raw + LIT_W'(1)) : lit_raw;
    mag_ext = CMP_W'(lit_mag);
    idx_ext = CMP_W'(variable_index_i);
    lit_ok  = (lit_mag != '0) && (mag_ext < CMP_W'(MAX_VARIABLES));
    wr_ok   = idx_ext < CMP_W'(MAX_VARIABLES);
    ram_we  = acc && (op == OP_WRITE) && wr_ok;
    ram_re  = acc && is_lit;
    s1_valid_d = acc && (op != OP_WRITE);
  end

  wcae_ram #(
    .WIDTH (1),
    .DEPTH (MAX_VARIABLES)
  ) u_assign_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_ext[VAR_AW-1:0]),
    .wdata_i (variable_value_i),
    .re_i    (ram_re),
    .raddr_i (mag_ext[VAR_AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_op_q     <= op;
      s1_lit_ok_q <= lit_ok && is_lit;
      s1_neg_q    <= lit_neg;
      s1_end_q    <= clause_end_i;
      s1_weight_q <= soft_weight_i;
    end
  end

  // lookup result joins the classified word here
  always_comb begin
    q_push_o            = s1_valid_q;
    q_work_o.op         = s1_op_q;
    q_work_o.matched    = s1_lit_ok_q & (ram_rdata ^ s1_neg_q);
    q_work_o.clause_end = s1_end_q;
    q_work_o.weight     = s1_weight_q;
  end

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push_o |-> !q_stat_i.full)
    else $error("word pushed into a full queue");

  a_write_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !s1_valid_q)
    else $error("assignment write produced a queue word");

endmodule

/* rtl/wcae_queue.sv */
module wcae_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  wcae_pkg::work_t   work_i,
  input  logic              pop_i,
  output logic              avail_o,
  output wcae_pkg::work_t   head_o,
  output wcae_pkg::q_stat_t stat_o
);
  import wcae_pkg::*;

  work_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] count_q, count_d;

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + QPTR_W'(1) : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + QPTR_W'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCNT_W'(1);
    end else if (!push_i && pop_i) begin
      count_d = count_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= work_i;
    end
  end

  assign avail_o            = count_q != '0;
  assign head_o             = mem_q[rd_ptr_q];
  assign stat_o.full        = count_q >= QCNT_W'(QUEUE_DEPTH);
  assign stat_o.almost_full = count_q >= QCNT_W'(QUEUE_DEPTH - 1);

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> avail_o)
    else $error("queue popped while empty");

endmodule

/* rtl/wcae_back.sv */
module wcae_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        avail_i,
  input  wcae_pkg::work_t             head_i,
  output logic                        q_pop_o,
  output logic                        empty_o,
  input  logic                        pop_i,
  output logic                        hard_all_satisfied_o,
  output logic [wcae_pkg::COST_W-1:0] soft_cost_o
);
  import wcae_pkg::*;

  logic              matched_q, matched_d;
  logic              hard_ok_q, hard_ok_d;
  logic [COST_W-1:0] cost_q, cost_d;
  logic              res_valid_q, res_valid_d;
  logic              res_hard_q;
  logic [COST_W-1:0] res_cost_q;

  logic              res_take;
  logic              is_fin;
  logic              fin_take;
  logic              any_match;
  logic [COST_W:0]   sum;

  always_comb begin
    res_take  = !res_valid_q || pop_i;
    is_fin    = head_i.op == OP_FINISH;
    q_pop_o   = avail_i && (!is_fin || res_take);
    fin_take  = q_pop_o && is_fin;
    any_match = matched_q | head_i.matched;
    sum       = {1'b0, cost_q} + (COST_W + 1)'(head_i.weight);

    matched_d   = matched_q;
    hard_ok_d   = hard_ok_q;
    cost_d      = cost_q;
    res_valid_d = res_valid_q && !pop_i;

    if (fin_take) begin
      hard_ok_d   = 1'b1;
      cost_d      = '0;
      matched_d   = 1'b0;
      res_valid_d = 1'b1;
    end else if (q_pop_o) begin
      if (head_i.clause_end) begin
        matched_d = 1'b0;
        if (!any_match) begin
          // the closing literal's opcode decides the clause kind
          if (head_i.op == OP_HARD) begin
            hard_ok_d = 1'b0;
          end else begin
            cost_d = sum[COST_W] ? '1 : sum[COST_W-1:0];
          end
        end
      end else begin
        matched_d = any_match;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matched_q   <= 1'b0;
      hard_ok_q   <= 1'b1;
      cost_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      matched_q   <= matched_d;
      hard_ok_q   <= hard_ok_d;
      cost_q      <= cost_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_take) begin
      res_hard_q <= hard_ok_q;
      res_cost_q <= cost_q;
    end
  end

  assign empty_o              = !res_valid_q;
  assign hard_all_satisfied_o = res_hard_q;
  assign soft_cost_o          = res_cost_q;

  a_fin_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_take |=> res_valid_q && hard_ok_q && (cost_q == '0) && !matched_q)
    else $error("finish did not report and clear");

  a_cost_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fin_take |=> cost_q >= $past(cost_q))
    else $error("cost decreased without finish");

endmodule

/* sim/wcae_checker.sv */
module wcae_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic                          full_i,
  input  wcae_pkg::op_e                 opcode_i,
  input  logic [wcae_pkg::VAR_W-1:0]    variable_index_i,
  input  logic                          variable_value_i,
  input  logic [wcae_pkg::LIT_W-1:0]    literal_i,
  input  logic                          clause_end_i,
  input  logic [wcae_pkg::WEIGHT_W-1:0] soft_weight_i,
  input  logic                          empty_i,
  input  logic                          pop_i,
  input  logic                          hard_all_satisfied_i,
  input  logic [wcae_pkg::COST_W-1:0]   soft_cost_i,
  output int unsigned                   errors_o,
  output int unsigned                   pending_o,
  output int unsigned                   reports_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import wcae_pkg::*;

  localparam logic [COST_W-1:0] COST_SAT = {COST_W{1'b1}};

  typedef struct packed {
    logic              hard_ok;
    logic [COST_W-1:0] cost;
  } report_t;

  // shadow of the block
  logic              truth_bits [MAX_VARIABLES];
  logic              clause_hit;
  logic              hard_ok;
  logic [COST_W-1:0] cost_sum;

  report_t     report_q [$];
  int unsigned errors;
  int unsigned reports;

  function automatic logic literal_true(logic [LIT_W-1:0] lit);
    logic [LIT_W:0] mag;
    mag = lit[LIT_W-1] ? ((LIT_W+1)'(1) << LIT_W) - {1'b0, lit} : {1'b0, lit};
    if (mag == 0 || mag >= MAX_VARIABLES) return 1'b0;
    return lit[LIT_W-1] ? !truth_bits[mag[VAR_AW-1:0]] : truth_bits[mag[VAR_AW-1:0]];
  endfunction

  function automatic void apply_word(op_e op, logic [VAR_W-1:0] idx, logic val,
                                     logic [LIT_W-1:0] lit, logic last,
                                     logic [WEIGHT_W-1:0] weight);
    logic [COST_W:0] sum;
    report_t         rep;
    case (op)
      OP_WRITE: begin
        if (idx < MAX_VARIABLES) truth_bits[idx] = val;
      end
      OP_FINISH: begin
        rep.hard_ok = hard_ok;
        rep.cost    = cost_sum;
        report_q.insert(report_q.size(), rep);
        hard_ok    = 1'b1;
        cost_sum   = '0;
        clause_hit = 1'b0;
      end
      default: begin
        if (literal_true(lit)) clause_hit = 1'b1;
        if (last) begin
          if (!clause_hit) begin
            if (op == OP_HARD) begin
              hard_ok = 1'b0;
            end else begin
              sum      = {1'b0, cost_sum} + weight;
              cost_sum = (sum > COST_SAT) ? COST_SAT : sum[COST_W-1:0];
            end
          end
          clause_hit = 1'b0;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    report_t want;
    if (!rst_ni) begin
      clause_hit = 1'b0;
      hard_ok    = 1'b1;
      cost_sum   = '0;
      report_q.delete();
      errors     = 0;
      reports    = 0;
    end else begin
      // a report leaving now belongs to an older finish, so compare first
      if (pop_i && !empty_i) begin
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t: report with none expected: hard %0b cost %0d", $time,
                   hard_all_satisfied_i, soft_cost_i);
        end else begin
          want = report_q.pop_front();
          reports++;
          if (hard_all_satisfied_i !== want.hard_ok) begin
            errors++;
            $display("%0t: hard_all_satisfied expected %0b actual %0b", $time,
                     want.hard_ok, hard_all_satisfied_i);
          end
          if (soft_cost_i !== want.cost) begin
            errors++;
            $display("%0t: soft_cost expected %0d actual %0d", $time,
                     want.cost, soft_cost_i);
          end
        end
      end
      if (push_i && !full_i) begin
        apply_word(opcode_i, variable_index_i, variable_value_i, literal_i,
                   clause_end_i, soft_weight_i);
      end
    end
    errors_o  <= errors;
    pending_o <= report_q.size();
    reports_o <= reports;
  end

endmodule

/* sim/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import wcae_pkg::*;

  // back-to-back full-weight soft misses that carry the cost into its upper bits
  localparam int unsigned HEAVY_RUN  = 200;
  // random words after the directed and heavy parts
  localparam int unsigned RAND_WORDS = 1420;
  // cycles with no word moving on either side before giving up
  localparam int unsigned IDLE_LIMIT = 2000;

  logic                  clk_i;
  logic                  rst_n;
  logic                  push;
  logic                  full;
  op_e                   opcode;
  logic [VAR_W-1:0]      variable_index;
  logic                  variable_value;
  logic [LIT_W-1:0]      literal;
  logic                  clause_end;
  logic [WEIGHT_W-1:0]   soft_weight;
  logic                  empty;
  logic                  pop;
  logic                  hard_all_satisfied;
  logic [COST_W-1:0]     soft_cost;

  int unsigned errors;
  int unsigned pending;
  int unsigned reports;

  // variables the store holds a known bit for; literals only name these
  bit          known_map [MAX_VARIABLES];
  int unsigned known_vars [$];

  bit          send_burst;
  bit          take_burst;
  int unsigned n_write, n_hard, n_soft, n_finish;

  weighted_cnf_assignment_evaluator i_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .push                 (push),
    .full                 (full),
    .opcode_i             (opcode),
    .variable_index_i     (variable_index),
    .variable_value_i     (variable_value),
    .literal_i            (literal),
    .clause_end_i         (clause_end),
    .soft_weight_i        (soft_weight),
    .empty                (empty),
    .pop                  (pop),
    .hard_all_satisfied_o (hard_all_satisfied),
    .soft_cost_o          (soft_cost)
  );

  wcae_checker i_checker (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .push_i               (push),
    .full_i               (full),
    .opcode_i             (opcode),
    .variable_index_i     (variable_index),
    .variable_value_i     (variable_value),
    .literal_i            (literal),
    .clause_end_i         (clause_end),
    .soft_weight_i        (soft_weight),
    .empty_i              (empty),
    .pop_i                (pop),
    .hard_all_satisfied_i (hard_all_satisfied),
    .soft_cost_i          (soft_cost),
    .errors_o             (errors),
    .pending_o            (pending),
    .reports_o            (reports)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // random literal over known variables; now and then zero or the
  // one magnitude that lies past the store
  function automatic logic [LIT_W-1:0] any_literal();
    int unsigned      pick;
    logic [LIT_W-1:0] mag;
    pick = $urandom_range(0, 19);
    if (pick == 0 || known_vars.size() == 0) return '0;
    if (pick == 1) return 17'h10000;
    mag = LIT_W'(known_vars[$urandom_range(0, known_vars.size() - 1)]);
    return $urandom_range(0, 1) ? LIT_W'(0 - mag) : mag;
  endfunction

  // weights lean on the edges: zero, all ones, anything
  function automatic logic [WEIGHT_W-1:0] any_weight();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // hand one word to the block; the gap before it is drawn per word
  task automatic send_word(op_e op, logic [VAR_W-1:0] idx, logic val,
                           logic [LIT_W-1:0] lit, logic last, logic [WEIGHT_W-1:0] weight);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    opcode         <= op;
    variable_index <= idx;
    variable_value <= val;
    literal        <= lit;
    clause_end     <= last;
    soft_weight    <= weight;
    push           <= 1'b1;
    do @(posedge clk_i); while (full);
    case (op)
      OP_WRITE: n_write++;
      OP_HARD:  n_hard++;
      OP_SOFT:  n_soft++;
      default:  n_finish++;
    endcase
  endtask

  // unused fields of each word still carry random, harmless content
  task automatic put_bit(logic [VAR_W-1:0] idx, logic val);
    send_word(OP_WRITE, idx, val, any_literal(), 1'($urandom), $urandom);
    if (!known_map[idx]) begin
      known_map[idx] = 1'b1;
      known_vars.insert(known_vars.size(), 32'(idx));
    end
  endtask

  task automatic put_lit(op_e op, logic [LIT_W-1:0] lit, logic last,
                         logic [WEIGHT_W-1:0] weight);
    send_word(op, VAR_W'($urandom), 1'($urandom), lit, last, weight);
  endtask

  task automatic put_finish();
    send_word(OP_FINISH, VAR_W'($urandom), 1'($urandom), any_literal(), 1'($urandom),
              $urandom);
  endtask

  // hold the sender off until every report has been taken
  task automatic drain();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  // one formula: refresh a few bits, stream clauses, then finish; a small
  // share is broken on purpose (writes and kind changes inside a clause,
  // finish with a clause still open)
  task automatic random_formula();
    int unsigned n_bits, n_clauses, n_lits;
    op_e         kind;
    bit          leave_open;
    n_bits     = (known_vars.size() == 0) ? 1 + $urandom_range(0, 5) : $urandom_range(0, 6);
    n_clauses  = $urandom_range(1, 8);
    leave_open = ($urandom_range(0, 9) == 0);
    repeat (n_bits) put_bit(VAR_W'($urandom), 1'($urandom));
    for (int c = 0; c < n_clauses; c++) begin
      kind   = $urandom_range(0, 1) ? OP_HARD : OP_SOFT;
      n_lits = $urandom_range(1, 4);
      for (int l = 0; l < n_lits; l++) begin
        if ($urandom_range(0, 19) == 0) put_bit(VAR_W'($urandom), 1'($urandom));
        if (l == n_lits - 1) begin
          put_lit(kind, any_literal(), !(leave_open && c == n_clauses - 1), any_weight());
        end else begin
          // the kind of a non-final literal does not matter to the clause
          put_lit(($urandom_range(0, 11) == 0) ? ((kind == OP_HARD) ? OP_SOFT : OP_HARD) : kind,
                  any_literal(), 1'b0, any_weight());
        end
      end
    end
    put_finish();
  endtask

  // result side: a fresh stall is drawn per report, with runs of none
  initial begin
    int unsigned gap;
    pop        <= 1'b0;
    take_burst  = 1'b0;
    @(posedge rst_n);
    forever begin
      if ($urandom_range(0, 15) == 0) take_burst = !take_burst;
      gap = take_burst ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do @(posedge clk_i); while (!(pop && !empty));
    end
  end

  // watchdog: any cycle that moves a word on either side resets it
  initial begin
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty)) idle = 0;
      else idle++;
    end
    $display("%0t: no word moved for %0d cycles, %0d reports outstanding", $time,
             IDLE_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int unsigned base;
    rst_n          <= 1'b0;
    push           <= 1'b0;
    opcode         <= OP_WRITE;
    variable_index <= '0;
    variable_value <= 1'b0;
    literal        <= '0;
    clause_end     <= 1'b0;
    soft_weight    <= '0;
    send_burst      = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // directed: index extremes, both values
    put_bit(16'd0, 1'b0);
    put_bit(16'd1, 1'b1);
    put_bit(16'd2, 1'b0);
    put_bit(16'hFFFF, 1'b1);
    put_bit(16'h8000, 1'b0);
    // satisfied hard clauses, positive and negative polarity
    put_lit(OP_HARD, 17'd1, 1'b1, '0);
    put_lit(OP_HARD, 17'(0 - 2), 1'b1, '1);
    // unmatched soft clauses: largest negative in range, zero literal,
    // magnitude past the store
    put_lit(OP_SOFT, 17'(0 - 65535), 1'b1, '1);
    put_lit(OP_SOFT, 17'd0, 1'b1, '0);
    put_lit(OP_SOFT, 17'h10000, 1'b1, 32'd1);
    put_finish();
    // unmatched hard clause of two literals
    put_lit(OP_HARD, 17'(0 - 1), 1'b0, '0);
    put_lit(OP_HARD, 17'd2, 1'b1, '0);
    // mixed kinds: the ending literal makes it soft
    put_lit(OP_HARD, 17'd0, 1'b0, '1);
    put_lit(OP_SOFT, 17'd0, 1'b1, 32'd5);
    // write inside an open clause reaches the later literal
    put_lit(OP_SOFT, 17'd0, 1'b0, '1);
    put_bit(16'd2, 1'b1);
    put_lit(OP_SOFT, 17'd2, 1'b1, 32'd7);
    // finish with a clause open drops it, then a finish with nothing
    put_lit(OP_HARD, 17'd0, 1'b0, '0);
    put_finish();
    put_finish();
    put_lit(OP_HARD, 17'd32768, 1'b0, '0);
    put_lit(OP_HARD, 17'd65535, 1'b1, '0);
    put_lit(OP_SOFT, 17'(0 - 32768), 1'b1, 32'd9);
    put_finish();
    drain();

    // heavy cost: a burst of full-weight misses carries well past 32 bits
    send_burst = 1'b1;
    repeat (HEAVY_RUN) put_lit(OP_SOFT, 17'd0, 1'b1, '1);
    put_finish();
    put_finish();
    send_burst = 1'b0;
    drain();

    // random formulas, sometimes at full rate, sometimes drained first
    base = n_write + n_hard + n_soft + n_finish;
    while (n_write + n_hard + n_soft + n_finish - base < RAND_WORDS) begin
      send_burst = ($urandom_range(0, 7) == 0);
      if ($urandom_range(0, 19) == 0) drain();
      random_formula();
    end
    send_burst = 1'b0;
    drain();

    // stray reports would show up here
    repeat (20) @(posedge clk_i);
    $display("words sent: %0d writes, %0d hard and %0d soft literals, %0d finishes",
             n_write, n_hard, n_soft, n_finish);
    $display("reports compared: %0d, one after a burst of %0d full-weight soft misses",
             reports, HEAVY_RUN);
    if (errors == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/wcae_pkg.sv
rtl/wcae_ram.sv
rtl/wcae_front.sv
rtl/wcae_queue.sv
rtl/wcae_back.sv
rtl/weighted_cnf_assignment_evaluator.sv
sim/wcae_checker.sv
sim/tb.sv
